@@ rtl/m68k_misc_pkg.sv @@
// Shared types and decode constants for the group-4 misc data unit.
package m68k_misc_pkg;

  typedef struct packed {
    logic [15:0] op;
    logic [31:0] operand;
    logic [31:0] aux_operand;
    logic [15:0] status;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result;
    logic [1:0]  size_code;
    logic        write_back;
    logic [15:0] new_status;
    logic        take_exception;
    logic [7:0]  vector_number;
    logic        handled;
  } out_item_t;

  // operation classes found by the front end
  typedef enum logic [4:0] {
    CL_NONE, CL_NEGX, CL_CLR, CL_NEG, CL_NOT, CL_TST, CL_TRAPV, CL_TRAP,
    CL_SWAP, CL_EXTW, CL_EXTL, CL_NBCD, CL_CHK, CL_MFSR, CL_MCCR,
    CL_ILLEGAL, CL_TAS
  } op_class_t;

  typedef struct packed {
    op_class_t   cls;
    logic [1:0]  sz;
    logic [3:0]  trap_n;
    logic [31:0] operand;
    logic [15:0] aux_w;
    logic [15:0] status;
  } dec_item_t;

  localparam logic [15:0] OP_ILLEGAL      = 16'h4AFC;
  localparam logic [15:0] OP_TRAPV        = 16'h4E76;
  localparam logic [15:0] OP_TRAP         = 16'h4E40;
  localparam logic [15:0] MASK_NIB        = 16'hFFF0;
  localparam logic [15:0] MASK_REG        = 16'hFFF8;
  localparam logic [15:0] OP_SWAP         = 16'h4840;
  localparam logic [15:0] OP_EXTL         = 16'h48C0;
  localparam logic [15:0] OP_EXTW         = 16'h4880;
  localparam logic [15:0] MASK_EA         = 16'hFFC0;
  localparam logic [15:0] OP_NBCD         = 16'h4800;
  localparam logic [15:0] OP_TAS          = 16'h4AC0;
  localparam logic [15:0] OP_MOVE_CCR     = 16'h44C0;
  localparam logic [15:0] OP_MOVE_FROM_SR = 16'h40C0;
  localparam logic [7:0]  TAS_BIT         = 8'h80;

  localparam logic [7:0] VEC_ILLEGAL = 8'd4;
  localparam logic [7:0] VEC_CHK     = 8'd6;
  localparam logic [7:0] VEC_TRAPV   = 8'd7;
  localparam logic [7:0] VEC_TRAP    = 8'd32;

  localparam int SR_C = 0;
  localparam int SR_V = 1;
  localparam int SR_Z = 2;
  localparam int SR_N = 3;
  localparam int SR_X = 4;

endpackage

@@ rtl/m68k_misc_group_data_unit.sv @@
// Top level of the group-4 misc data unit: decode, queue, execute.
//  channel | direction | handshake        | payload
//  in_     | input     | in_push/in_full   | in_item (in_item_t)
//  out_    | output    | out_pop/out_empty | out_item (out_item_t)
// One item per cycle sustained while out_pop keeps up; an accepted push reaches
// the output through the decode register, queue write, queue RAM read and execute skid.
// Synchronous active-low reset empties all stages; no clearing pass.
// A stalled out_pop fills the skid, then the queue, then the decode register, then raises in_full.
module m68k_misc_group_data_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  m68k_misc_pkg::in_item_t  in_item,
  output logic                     out_empty,
  input  logic                     out_pop,
  output m68k_misc_pkg::out_item_t out_item
);
  import m68k_misc_pkg::*;

  logic      in_ready, d_valid, d_ready, q_valid, q_ready, out_valid;
  dec_item_t d_item, q_item;

  assign in_full   = !in_ready;
  assign out_empty = !out_valid;

  m68k_misc_decode u_dec (
    .clk(clk), .rst_n(rst_n), .in_valid(in_push), .in_ready(in_ready),
    .in_item(in_item), .dq_valid(d_valid), .dq_ready(d_ready), .dq_item(d_item)
  );

  m68k_misc_queue u_q (
    .clk(clk), .rst_n(rst_n), .wr_valid(d_valid), .wr_ready(d_ready),
    .wr_item(d_item), .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  m68k_misc_exec u_exe (
    .clk(clk), .rst_n(rst_n), .dq_valid(q_valid), .dq_ready(q_ready),
    .dq_item(q_item), .out_valid(out_valid), .out_ready(out_pop),
    .out_item(out_item)
  );
endmodule

@@ rtl/m68k_misc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module m68k_misc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/m68k_misc_decode.sv @@
// Front end: classifies the instruction word and registers a decoded beat.
module m68k_misc_decode (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  m68k_misc_pkg::in_item_t  in_item,
  output logic                     dq_valid,
  input  logic                     dq_ready,
  output m68k_misc_pkg::dec_item_t dq_item
);
  import m68k_misc_pkg::*;

  logic      valid_r, valid_nxt;
  dec_item_t item_r;
  dec_item_t dec;
  logic [3:0] opf;
  logic [1:0] szf;
  logic [15:0] op;

  assign in_ready = !valid_r || dq_ready;

  // opcode classification, in priority order
  always_comb begin
    op  = in_item.op;
    opf = op[11:8];
    szf = op[7:6];
    dec.cls     = CL_NONE;
    dec.sz      = 2'd0;
    dec.trap_n  = op[3:0];
    dec.operand = in_item.operand;
    dec.aux_w   = in_item.aux_operand[15:0];
    dec.status  = in_item.status;
    if (op[15:12] != 4'd4) begin
      dec.cls = CL_NONE;
    end else if (szf != 2'd3 && (opf == 4'h0 || opf == 4'h2 || opf == 4'h4 ||
                                 opf == 4'h6 || opf == 4'hA)) begin
      dec.sz = szf;
      case (opf)
        4'h0:    dec.cls = CL_NEGX;
        4'h2:    dec.cls = CL_CLR;
        4'h4:    dec.cls = CL_NEG;
        4'h6:    dec.cls = CL_NOT;
        default: dec.cls = CL_TST;
      endcase
    end else if (op == OP_TRAPV) begin
      dec.cls = CL_TRAPV;
    end else if ((op & MASK_NIB) == OP_TRAP) begin
      dec.cls = CL_TRAP;
    end else if ((op & MASK_REG) == OP_SWAP) begin
      dec.cls = CL_SWAP; dec.sz = 2'd2;
    end else if ((op & MASK_REG) == OP_EXTW) begin
      dec.cls = CL_EXTW; dec.sz = 2'd1;
    end else if ((op & MASK_REG) == OP_EXTL) begin
      dec.cls = CL_EXTL; dec.sz = 2'd2;
    end else if ((op & MASK_EA) == OP_NBCD) begin
      dec.cls = CL_NBCD;
    end else if (op[8:6] == 3'b111) begin
      dec.cls = CL_NONE;
    end else if (op[8:6] == 3'b110) begin
      dec.cls = CL_CHK; dec.sz = 2'd1;
    end else if ((op & MASK_EA) == OP_MOVE_FROM_SR) begin
      dec.cls = CL_MFSR; dec.sz = 2'd1;
    end else if ((op & MASK_EA) == OP_MOVE_CCR) begin
      dec.cls = CL_MCCR; dec.sz = 2'd1;
    end else if (op == OP_ILLEGAL) begin
      dec.cls = CL_ILLEGAL;
    end else if ((op & MASK_EA) == OP_TAS) begin
      dec.cls = CL_TAS;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) valid_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
    if (in_valid && in_ready) item_r <= dec;
  end

  assign dq_valid = valid_r;
  assign dq_item  = item_r;
endmodule

@@ rtl/m68k_misc_queue.sv @@
// Two-entry queue between decode and execute, storage in the generic RAM.
module m68k_misc_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_valid,
  output logic                     wr_ready,
  input  m68k_misc_pkg::dec_item_t wr_item,
  output logic                     rd_valid,
  input  logic                     rd_ready,
  output m68k_misc_pkg::dec_item_t rd_item
);
  import m68k_misc_pkg::*;

  localparam int W = $bits(dec_item_t);

  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       out_v_r, out_v_nxt;
  logic       push, fetch, ram_v_r;
  logic [W-1:0] rdata;
  dec_item_t  hold_r;
  logic       use_hold_r;

  // RAM read is registered; a one-entry output latch keeps rd_item stable
  assign wr_ready = (cnt_r != 2'd2);
  assign push     = wr_valid && wr_ready;
  assign fetch    = (cnt_r != 2'd0) && (!out_v_r || rd_ready);

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ fetch;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, fetch};
    out_v_nxt = fetch ? 1'b1 : (rd_ready ? 1'b0 : out_v_r);
  end

  m68k_misc_ram #(.WIDTH(W), .DEPTH(2)) u_ram (
    .clk(clk), .we(push), .waddr(wp_r), .wdata(wr_item),
    .raddr(rp_r), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0; out_v_r <= 1'b0;
      ram_v_r <= 1'b0; use_hold_r <= 1'b0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt; out_v_r <= out_v_nxt;
      ram_v_r <= fetch;
      use_hold_r <= out_v_nxt && !fetch;
    end
    if (ram_v_r) hold_r <= rdata;
  end

  // write and read of the same slot in one cycle: count gate prevents it
  assign rd_valid = out_v_r;
  assign rd_item  = use_hold_r ? hold_r : dec_item_t'(rdata);
endmodule

@@ rtl/m68k_misc_exec.sv @@
// Back end: computes result and flags, holds them in a two-entry skid queue.
module m68k_misc_exec (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     dq_valid,
  output logic                     dq_ready,
  input  m68k_misc_pkg::dec_item_t dq_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output m68k_misc_pkg::out_item_t out_item
);
  import m68k_misc_pkg::*;

  out_item_t  r;
  logic [31:0] m, msb, d, neg, nx;
  logic [7:0]  bb, nb, nbp;
  logic        x;
  logic [15:0] sr;
  logic signed [15:0] bnd, val;

  // size mask and sign bit
  always_comb begin
    case (dq_item.sz)
      2'd0:    begin m = 32'h0000_00FF; msb = 32'h0000_0080; end
      2'd1:    begin m = 32'h0000_FFFF; msb = 32'h0000_8000; end
      default: begin m = 32'hFFFF_FFFF; msb = 32'h8000_0000; end
    endcase
  end

  always_comb begin
    d   = dq_item.operand & m;
    x   = dq_item.status[SR_X];
    sr  = dq_item.status;
    neg = (32'd0 - d) & m;
    nx  = (32'd0 - d - {31'd0, x}) & m;
    bb  = 8'h9A - dq_item.operand[7:0] - {7'd0, x};
    nb  = (bb[3:0] == 4'hA) ? ((bb & 8'hF0) + 8'h10) : bb;
    nbp = bb;
    bnd = dq_item.operand[15:0];
    val = dq_item.aux_w;
    r = '0;
    r.handled = 1'b1;
    r.size_code = dq_item.sz;
    case (dq_item.cls)
      CL_NEGX: begin
        sr[SR_N] = |(nx & msb); sr[SR_V] = |(d & nx & msb);
        sr[SR_C] = |((d | nx) & msb); sr[SR_X] = sr[SR_C];
        if (nx != 32'd0) sr[SR_Z] = 1'b0;
        r.result = nx; r.write_back = 1'b1;
      end
      CL_CLR: begin
        sr[SR_N] = 1'b0; sr[SR_V] = 1'b0; sr[SR_C] = 1'b0; sr[SR_Z] = 1'b1;
        r.write_back = 1'b1;
      end
      CL_NEG: begin
        sr[SR_N] = |(neg & msb); sr[SR_Z] = (neg == 32'd0);
        sr[SR_V] = |(d & neg & msb); sr[SR_C] = (d != 32'd0); sr[SR_X] = sr[SR_C];
        r.result = neg; r.write_back = 1'b1;
      end
      CL_NOT: begin
        r.result = ~d & m; r.write_back = 1'b1;
        sr[SR_N] = |(r.result & msb); sr[SR_Z] = (r.result == 32'd0);
        sr[SR_V] = 1'b0; sr[SR_C] = 1'b0;
      end
      CL_TST: begin
        r.result = d;
        sr[SR_N] = |(d & msb); sr[SR_Z] = (d == 32'd0);
        sr[SR_V] = 1'b0; sr[SR_C] = 1'b0;
      end
      CL_TRAPV: begin
        if (sr[SR_V]) begin r.take_exception = 1'b1; r.vector_number = VEC_TRAPV; end
      end
      CL_TRAP: begin
        r.take_exception = 1'b1;
        r.vector_number  = VEC_TRAP | {4'd0, dq_item.trap_n};
      end
      CL_SWAP: begin
        r.result = {dq_item.operand[15:0], dq_item.operand[31:16]};
        r.write_back = 1'b1;
        sr[SR_N] = r.result[31]; sr[SR_Z] = (r.result == 32'd0);
        sr[SR_V] = 1'b0; sr[SR_C] = 1'b0;
      end
      CL_EXTW: begin
        r.result = {dq_item.operand[31:16], {8{dq_item.operand[7]}},
                    dq_item.operand[7:0]};
        r.write_back = 1'b1;
        sr[SR_N] = dq_item.operand[7]; sr[SR_Z] = (dq_item.operand[7:0] == 8'd0);
        sr[SR_V] = 1'b0; sr[SR_C] = 1'b0;
      end
      CL_EXTL: begin
        r.result = {{16{dq_item.operand[15]}}, dq_item.operand[15:0]};
        r.write_back = 1'b1;
        sr[SR_N] = dq_item.operand[15]; sr[SR_Z] = (dq_item.operand[15:0] == 16'd0);
        sr[SR_V] = 1'b0; sr[SR_C] = 1'b0;
      end
      CL_NBCD: begin
        sr[SR_N] = 1'b0; sr[SR_V] = 1'b0; sr[SR_C] = 1'b0; sr[SR_X] = 1'b0;
        if (bb != 8'h9A) begin
          sr[SR_N] = nb[7]; sr[SR_V] = ~nbp[7] & nb[7];
          sr[SR_C] = 1'b1; sr[SR_X] = 1'b1;
          if (nb != 8'd0) sr[SR_Z] = 1'b0;
          r.result = {24'd0, nb};
        end
        r.write_back = 1'b1;
      end
      CL_CHK: begin
        sr[SR_N] = val[15]; sr[SR_Z] = 1'b0; sr[SR_V] = 1'b0; sr[SR_C] = 1'b0;
        if (val[15] || val > bnd) begin
          r.take_exception = 1'b1; r.vector_number = VEC_CHK;
        end
      end
      CL_MFSR: begin
        r.result = {16'd0, dq_item.status}; r.write_back = 1'b1;
      end
      CL_MCCR: begin
        sr = {dq_item.status[15:8], 3'd0, dq_item.operand[4:0]};
      end
      CL_ILLEGAL: begin
        r.take_exception = 1'b1; r.vector_number = VEC_ILLEGAL;
      end
      CL_TAS: begin
        r.result = {24'd0, dq_item.operand[7:0] | TAS_BIT}; r.write_back = 1'b1;
        sr[SR_N] = dq_item.operand[7]; sr[SR_Z] = (dq_item.operand[7:0] == 8'd0);
        sr[SR_V] = 1'b0; sr[SR_C] = 1'b0;
      end
      default: begin
        r.handled = 1'b0; r.size_code = 2'd0;
      end
    endcase
    r.new_status = sr;
  end

  // two-entry output skid: main slot plus spare
  logic      v0_r, v1_r;
  out_item_t s0_r, s1_r;
  logic      take, pop;

  assign dq_ready = !v1_r;
  assign take     = dq_valid && dq_ready;
  assign pop      = v0_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0;
    end else begin
      if (pop) begin
        v0_r <= v1_r || take;
        v1_r <= v1_r && take;
      end else if (take) begin
        v0_r <= 1'b1;
        v1_r <= v0_r;
      end
    end
    if (pop) begin
      s0_r <= v1_r ? s1_r : r;
      if (v1_r) s1_r <= r;
    end else if (take) begin
      if (v0_r) s1_r <= r;
      else      s0_r <= r;
    end
  end

  assign out_valid = v0_r;
  assign out_item  = s0_r;
endmodule

@@ rtl/m68k_misc_checker.sv @@
// Port-level assertions for the misc data unit, bound to the top level.
module m68k_misc_props (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_full,
  input logic                     out_empty,
  input logic                     out_pop,
  input m68k_misc_pkg::out_item_t out_item
);
  import m68k_misc_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("result changed while stalled");

  // nothing comes out and the input is open right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("bad state after reset");

  // unhandled opcodes never raise exceptions or write back
  a_unh: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.handled) |->
      (!out_item.take_exception && !out_item.write_back))
    else $error("unhandled beat has side effects");

  // exception implies a nonzero vector
  a_vec: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.take_exception) |-> (out_item.vector_number != 8'd0))
    else $error("exception without vector");
endmodule

bind m68k_misc_group_data_unit m68k_misc_props u_chk (
  .clk(clk), .rst_n(rst_n), .in_full(in_full),
  .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
);
